/* rtl/bsr_pkg.sv */
// Shared types, codes and helper functions for the bitstream reader with start-code seek.
// Depends on nothing; imported by the controller, the datapath and the top level.
`default_nettype none

package bsr_pkg;

    // Stream word width and the width of the bit counter that spans one word.
    localparam int WORD_BITS = 32;
    localparam int BL_W      = $clog2(WORD_BITS + 1);

    // Input item kinds.
    localparam logic [2:0] KIND_WORD   = 3'd0;
    localparam logic [2:0] KIND_BIT    = 3'd1;
    localparam logic [2:0] KIND_PEEK8  = 3'd2;
    localparam logic [2:0] KIND_PEEK16 = 3'd3;
    localparam logic [2:0] KIND_SKIP   = 3'd4;
    localparam logic [2:0] KIND_ALIGN  = 3'd5;
    localparam logic [2:0] KIND_ABYTE  = 3'd6;
    localparam logic [2:0] KIND_SEEK   = 3'd7;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_STARVED = 2'd1;
    localparam logic [1:0] STATUS_REJECT  = 2'd2;

    // Start-code match progress.
    localparam logic [2:0] STAGE_IDLE  = 3'd0;
    localparam logic [2:0] STAGE_ONE   = 3'd1;
    localparam logic [2:0] STAGE_TWO   = 3'd2;
    localparam logic [2:0] STAGE_THREE = 3'd3;
    localparam logic [2:0] STAGE_FOUR  = 3'd4;
    localparam logic [2:0] STAGE_HIT   = 3'd5;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] BYTE_NAL  = 8'h65;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEEK
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic run_cmd;     // execute a non-seek item from the input beat
        logic seek_align;  // byte-align at the start of a seek
        logic seek_mode;   // controller is in the seek loop
        logic seek_step;   // commit one seek byte step
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_final;  // the current seek step ends the seek
    } dp_stat_t;

    // Top 16 bits of the unread part of the two-word window.
    function automatic logic [15:0] win_top(logic [WORD_BITS-1:0] cur,
                                            logic [WORD_BITS-1:0] nxt,
                                            logic [BL_W-1:0] bl);
        logic [2*WORD_BITS-1:0] win;
        logic [BL_W:0]          sh;
        win = {cur, nxt};
        sh  = {1'b0, bl} + (BL_W + 1)'(16);
        return 16'(win >> sh);
    endfunction

    // Start-code matcher transition.
    function automatic logic [2:0] next_stage(logic [2:0] st, logic [7:0] b);
        logic [2:0] ns;
        unique case (st)
            STAGE_ONE:   ns = (b == BYTE_ZERO) ? STAGE_TWO : STAGE_IDLE;
            STAGE_TWO:   ns = (b == BYTE_ZERO) ? STAGE_THREE : STAGE_IDLE;
            STAGE_THREE: ns = (b == BYTE_ONE) ? STAGE_FOUR :
                              ((b == BYTE_ZERO) ? STAGE_THREE : STAGE_IDLE);
            STAGE_FOUR:  ns = (b == BYTE_NAL) ? STAGE_HIT :
                              ((b == BYTE_ZERO) ? STAGE_ONE : STAGE_IDLE);
            default:     ns = (b == BYTE_ZERO) ? STAGE_ONE : STAGE_IDLE;
        endcase
        return ns;
    endfunction

endpackage

`default_nettype wire

/* rtl/bsr_ctrl.sv */
// Controller state machine: input/output handshakes and sequencing of the seek loop.
// Depends on bsr_pkg for the state type, item kinds and command/status structs.
`default_nettype none

module bsr_ctrl
    import bsr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] kind,
    output logic            out_valid,
    input  wire logic       out_ready,
    output dp_cmd_t         cmd,
    input  wire dp_stat_t   stat
);

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       accept;

    // The result register can take a new beat when empty or being drained.
    assign out_free  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind == KIND_SEEK)
                begin
                    state_next = ST_SEEK;
                end
            end
            ST_SEEK:
            begin
                if (stat.step_final && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output and command logic.
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = out_free;
                cmd.run_cmd    = in_valid && out_free && (kind != KIND_SEEK);
                cmd.seek_align = in_valid && out_free && (kind == KIND_SEEK);
            end
            ST_SEEK:
            begin
                cmd.seek_mode = 1'b1;
                cmd.seek_step = !stat.step_final || out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || cmd.run_cmd ||
                         (cmd.seek_step && stat.step_final);
    end

    // State and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A seek in progress blocks new input beats.
    a_seek_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEEK) |-> !in_ready)
        else $error("input accepted during seek");

    // A final seek step always leaves the seek loop with a result.
    a_final_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.seek_step && stat.step_final) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("final seek step lost its result");

    // No item or seek completes while an undrained result still occupies the register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(cmd.run_cmd ||
                                            (cmd.seek_step && stat.step_final)))
        else $error("result register overwritten");

endmodule

`default_nettype wire

/* rtl/bsr_dp.sv */
// Datapath: two-word bit window, bit counter, start-code matcher and result register.
// Depends on bsr_pkg for constants, command/status structs and helper functions.
`default_nettype none

module bsr_dp
    import bsr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat,
    input  wire logic [2:0]           kind,
    input  wire logic [WORD_BITS-1:0] word,
    input  wire logic [5:0]           skip_count,
    output logic [15:0]               value,
    output logic [1:0]                status,
    output logic                      found
);

    localparam logic [BL_W-1:0] BL_FULL = BL_W'(WORD_BITS);

    logic [WORD_BITS-1:0] cur_reg, cur_next;
    logic [WORD_BITS-1:0] nxt_reg, nxt_next;
    logic                 nv_reg, nv_next;
    logic [BL_W-1:0]      bl_reg, bl_next;
    logic [2:0]           ms_reg, ms_next;
    logic [15:0]          value_reg;
    logic [1:0]           status_reg;
    logic                 found_reg;

    logic [15:0]          res_value;
    logic [1:0]           res_status;
    logic                 res_found;

    logic                 starved;
    logic                 refill;
    logic [BL_W-1:0]      bl_base;
    logic [BL_W-1:0]      bl_eff;
    logic [BL_W-1:0]      bl_al;
    logic [BL_W-1:0]      cnt_sat;
    logic [WORD_BITS-1:0] cur_eff;
    logic [15:0]          top;
    logic [2:0]           stage_new;
    logic                 match_hit;
    logic                 load_out;

    // Aligned count and saturated skip count.
    assign bl_al   = {bl_reg[BL_W-1:3], 3'b000};
    assign cnt_sat = (skip_count > 6'(WORD_BITS)) ? BL_FULL : BL_W'(skip_count);

    // Mode decode: starvation, refill need and the pre-refill bit count.
    always_comb
    begin
        starved = 1'b0;
        refill  = 1'b0;
        bl_base = bl_reg;
        if (cmd.seek_mode)
        begin
            starved = (bl_reg == '0) && !nv_reg;
            refill  = (bl_reg == '0);
        end
        else
        begin
            unique case (kind)
                KIND_BIT:
                begin
                    starved = (bl_reg == '0) && !nv_reg;
                    refill  = (bl_reg == '0);
                end
                KIND_PEEK8, KIND_ABYTE:
                begin
                    starved = (bl_reg < BL_W'(8)) && !nv_reg;
                    if (kind == KIND_ABYTE)
                    begin
                        bl_base = bl_al;
                    end
                    refill  = (kind == KIND_ABYTE) ? (bl_al == '0) : (bl_reg == '0);
                end
                KIND_PEEK16:
                begin
                    starved = (bl_reg < BL_W'(16)) && !nv_reg;
                    refill  = (bl_reg == '0);
                end
                KIND_SKIP:
                begin
                    starved = (cnt_sat > bl_reg) && !nv_reg;
                    refill  = (cnt_sat > bl_reg);
                end
                KIND_WORD, KIND_ALIGN, KIND_SEEK:
                begin
                    starved = 1'b0;
                end
            endcase
        end
    end

    // Window after an optional refill, and the bits at its read point.
    assign bl_eff    = refill ? BL_FULL : bl_base;
    assign cur_eff   = refill ? nxt_reg : cur_reg;
    assign top       = win_top(cur_eff, nxt_reg, bl_eff);
    assign stage_new = next_stage(ms_reg, top[15:8]);
    assign match_hit = !starved && (stage_new == STAGE_HIT);

    assign stat.step_final = starved || match_hit;

    // State update and result formation.
    always_comb
    begin
        cur_next   = cur_reg;
        nxt_next   = nxt_reg;
        nv_next    = nv_reg;
        bl_next    = bl_reg;
        ms_next    = ms_reg;
        res_value  = '0;
        res_status = STATUS_DONE;
        res_found  = 1'b0;
        if (cmd.seek_step)
        begin
            if (starved)
            begin
                res_status = STATUS_STARVED;
            end
            else
            begin
                cur_next = cur_eff;
                nv_next  = nv_reg && !refill;
                bl_next  = bl_eff - BL_W'(8);
                if (match_hit)
                begin
                    ms_next   = STAGE_IDLE;
                    res_found = 1'b1;
                end
                else
                begin
                    ms_next = stage_new;
                end
            end
        end
        else if (cmd.seek_align)
        begin
            bl_next = bl_al;
        end
        else if (cmd.run_cmd)
        begin
            unique case (kind)
                KIND_WORD:
                begin
                    if (nv_reg)
                    begin
                        res_status = STATUS_REJECT;
                    end
                    else
                    begin
                        nxt_next = word;
                        nv_next  = 1'b1;
                    end
                end
                KIND_BIT, KIND_PEEK8, KIND_PEEK16, KIND_ABYTE:
                begin
                    if (starved)
                    begin
                        res_status = STATUS_STARVED;
                    end
                    else
                    begin
                        cur_next = cur_eff;
                        nv_next  = nv_reg && !refill;
                        bl_next  = bl_eff;
                        if (kind == KIND_BIT)
                        begin
                            res_value = {15'd0, top[15]};
                            bl_next   = bl_eff - BL_W'(1);
                        end
                        else if (kind == KIND_PEEK16)
                        begin
                            res_value = top;
                        end
                        else
                        begin
                            res_value = {8'd0, top[15:8]};
                            if (kind == KIND_ABYTE)
                            begin
                                bl_next = bl_eff - BL_W'(8);
                            end
                        end
                    end
                end
                KIND_SKIP:
                begin
                    if (starved)
                    begin
                        res_status = STATUS_STARVED;
                    end
                    else if (refill)
                    begin
                        cur_next = nxt_reg;
                        nv_next  = 1'b0;
                        bl_next  = BL_FULL + bl_reg - cnt_sat;
                    end
                    else
                    begin
                        bl_next = bl_reg - cnt_sat;
                    end
                end
                KIND_ALIGN:
                begin
                    bl_next = bl_al;
                end
                KIND_SEEK:
                begin
                    res_status = STATUS_DONE;
                end
            endcase
        end
    end

    assign load_out = cmd.run_cmd || (cmd.seek_step && stat.step_final);

    // Window, counter and matcher registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            nxt_reg <= '0;
            nv_reg  <= 1'b0;
            bl_reg  <= '0;
            ms_reg  <= STAGE_IDLE;
        end
        else
        begin
            cur_reg <= cur_next;
            nxt_reg <= nxt_next;
            nv_reg  <= nv_next;
            bl_reg  <= bl_next;
            ms_reg  <= ms_next;
        end
    end

    // Result register, loaded once per finished item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg  <= '0;
            status_reg <= STATUS_DONE;
            found_reg  <= 1'b0;
        end
        else if (load_out)
        begin
            value_reg  <= res_value;
            status_reg <= res_status;
            found_reg  <= res_found;
        end
    end

    assign value  = value_reg;
    assign status = status_reg;
    assign found  = found_reg;

    // The bit counter never exceeds one word.
    a_bits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bl_reg <= BL_FULL)
        else $error("bit counter beyond word size");

    // The matcher never rests on the hit stage or above it.
    a_stage_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ms_reg <= STAGE_FOUR)
        else $error("match stage out of range");

    // A found start code or a nonzero value only come with a done status.
    a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg || value_reg != '0) |-> (status_reg == STATUS_DONE))
        else $error("result fields disagree with status");

    // Each seek step consumes a whole byte from an aligned position.
    a_seek_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seek_mode |-> (bl_reg[2:0] == 3'b000))
        else $error("seek running unaligned");

endmodule

`default_nettype wire

/* rtl/bitstream_reader_start_code_seek_unit.sv */
// Bitstream reader with start-code seek: MSB-first bit reader over a two-word window.
//
// Input channel (in_valid/in_ready) carries one item per beat: kind, word and
// skip_count. Kind 0 loads a stream word into the one-word next slot; kinds 1-6
// take a bit, peek 8 or 16 bits, skip up to 32 bits, align, or take an aligned
// byte; kind 7 seeks the byte pattern 00 00 00 01 65.
// Output channel (out_valid/out_ready) returns one result beat per item:
// value, status and found.
// A word or bit/byte command is executed at the accepting edge and its result is
// valid in the next cycle, one item per cycle while out_ready stays high. A seek
// byte-aligns when accepted and then consumes one byte of the window per step,
// at most eight bytes, until a match or a dry window; the result appears the cycle
// after the last step. Throughput is set by the single-byte step of the seek loop.
// Reset clears the window, empties the next slot, zeroes the bit counter and
// the match stage, and leaves no result pending.
// A stalled receiver holds the result beat steady; outside a seek a new item is taken
// in the cycle the pending result is drained, or at once if none is pending.
`default_nettype none

module bitstream_reader_start_code_seek_unit
    import bsr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [2:0]           kind,
    input  wire logic [WORD_BITS-1:0] word,
    input  wire logic [5:0]           skip_count,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [15:0]               value,
    output logic [1:0]                status,
    output logic                      found
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Handshake and sequencing.
    bsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Window, counter, matcher and result register.
    bsr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (kind),
        .word       (word),
        .skip_count (skip_count),
        .value      (value),
        .status     (status),
        .found      (found)
    );

endmodule

`default_nettype wire
